// ===== src/fws_pkg.sv =====
package fws_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned DATA_WIDTH_DEF  = 32;

  // Request selector codes on the input channel
  localparam logic [2:0] REQ_PUSH  = 3'd0;
  localparam logic [2:0] REQ_POP   = 3'd1;
  localparam logic [2:0] REQ_FRONT = 3'd2;
  localparam logic [2:0] REQ_FIND  = 3'd3;
  localparam logic [2:0] REQ_SWAP  = 3'd4;
  localparam logic [2:0] REQ_READ  = 3'd5;
  localparam logic [2:0] REQ_CLEAR = 3'd6;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_POP,
    OP_FRONT,
    OP_FIND,
    OP_SWAP,
    OP_READ,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] value;
    logic [3:0]  position;
  } cmd_t;

  typedef struct packed {
    logic [31:0] data_out;
    logic [3:0]  found_position;
    logic [1:0]  status;
    logic [4:0]  entry_count;
    logic        is_empty;
  } res_t;

endpackage

// ===== src/fws_in_if.sv =====
interface fws_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [31:0] value;
  logic [3:0]  position;

  modport source (output valid, output req_type, output value, output position, input ready);
  modport sink (input valid, input req_type, input value, input position, output ready);
endinterface

// ===== src/fws_out_if.sv =====
interface fws_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_out;
  logic [3:0]  found_position;
  logic [1:0]  status;
  logic [4:0]  entry_count;
  logic        is_empty;

  modport source (output valid, output data_out, output found_position, output status,
                  output entry_count, output is_empty, input ready);
  modport sink (input valid, input data_out, input found_position, input status,
                input entry_count, input is_empty, output ready);
endinterface

// ===== src/fws_ram.sv =====
module fws_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/fws_front.sv =====
module fws_front (
  input  logic          clk,
  input  logic          rst_n,
  fws_in_if.sink        in_ch,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output fws_pkg::cmd_t cmd
);

  localparam int unsigned CQ_DEPTH = 2;
  localparam int unsigned CQ_AW    = $clog2(CQ_DEPTH);
  localparam int unsigned CQ_CW    = $clog2(CQ_DEPTH + 1);

  fws_pkg::cmd_t    q_r [CQ_DEPTH];
  logic [CQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CQ_CW-1:0] cnt_r, cnt_nxt;
  fws_pkg::cmd_t    dec;
  logic             push, pop;

  // Classify the request selector; the unused code becomes a no-op
  always_comb begin
    dec.value    = in_ch.value;
    dec.position = in_ch.position;
    case (in_ch.req_type)
      fws_pkg::REQ_PUSH:  dec.op = fws_pkg::OP_PUSH;
      fws_pkg::REQ_POP:   dec.op = fws_pkg::OP_POP;
      fws_pkg::REQ_FRONT: dec.op = fws_pkg::OP_FRONT;
      fws_pkg::REQ_FIND:  dec.op = fws_pkg::OP_FIND;
      fws_pkg::REQ_SWAP:  dec.op = fws_pkg::OP_SWAP;
      fws_pkg::REQ_READ:  dec.op = fws_pkg::OP_READ;
      fws_pkg::REQ_CLEAR: dec.op = fws_pkg::OP_CLEAR;
      default:            dec.op = fws_pkg::OP_NOP;
    endcase
  end

  assign in_ch.ready = (cnt_r != CQ_CW'(CQ_DEPTH));
  assign cmd_valid   = (cnt_r != '0);
  assign cmd         = q_r[rd_ptr_r];

  assign push = in_ch.valid && in_ch.ready;
  assign pop  = cmd_valid && cmd_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + CQ_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + CQ_AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CQ_CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CQ_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

// ===== src/fws_back.sv =====
module fws_back #(
  parameter int unsigned QUEUE_DEPTH = fws_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned DATA_WIDTH  = fws_pkg::DATA_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  fws_pkg::cmd_t cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output fws_pkg::res_t out_res
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned OW = ((CW > 4) ? CW : 4) + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_SWB  = 3'd3;
  localparam logic [2:0] S_SWWA = 3'd4;
  localparam logic [2:0] S_SWWB = 3'd5;

  function automatic logic [AW-1:0] ring(input logic [AW-1:0] base, input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
      sum = sum - (CW+1)'(QUEUE_DEPTH);
    end
    return AW'(sum);
  endfunction

  logic [2:0]            state_r, state_nxt;
  logic [AW-1:0]         head_r, head_nxt;
  logic [CW-1:0]         occ_r, occ_nxt;
  logic                  pop_r, pop_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic                  pend_r, pend_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic [DATA_WIDTH-1:0] tmp_r, tmp_nxt;
  logic [CW-1:0]         cmp_idx_r, cmp_idx_nxt;
  logic [AW-1:0]         addr_a_r, addr_a_nxt;
  logic [AW-1:0]         addr_b_r, addr_b_nxt;
  fws_pkg::res_t         res_r, res_nxt;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  fws_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cmd_ready = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  always_comb begin
    logic [DATA_WIDTH-1:0] dval;
    logic [OW-1:0]         posx;
    logic [OW-1:0]         occx;
    logic [CW-1:0]         posc;
    logic                  fin;
    logic                  hit;
    logic [31:0]           f_data;
    logic [3:0]            f_found;
    logic [1:0]            f_status;

    dval     = DATA_WIDTH'(cmd.value);
    posx     = OW'(cmd.position);
    occx     = OW'(occ_r);
    posc     = CW'(cmd.position);
    fin      = 1'b0;
    hit      = pend_r && (ram_rdata == val_r);
    f_data   = '0;
    f_found  = '0;
    f_status = fws_pkg::ST_OK;

    state_nxt     = state_r;
    head_nxt      = head_r;
    occ_nxt       = occ_r;
    pop_nxt       = pop_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    val_nxt       = val_r;
    tmp_nxt       = tmp_r;
    cmp_idx_nxt   = cmp_idx_r;
    addr_a_nxt    = addr_a_r;
    addr_b_nxt    = addr_b_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;

    ram_we    = 1'b0;
    ram_waddr = head_r;
    ram_wdata = dval;
    ram_raddr = head_r;

    // Drop the result once the transaction completes
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (cmd_valid && cmd_ready) begin
          case (cmd.op)
            fws_pkg::OP_PUSH: begin
              fin = 1'b1;
              if (occ_r >= CW'(QUEUE_DEPTH)) begin
                f_status = fws_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = ring(head_r, occ_r);
                occ_nxt   = occ_r + CW'(1);
              end
            end
            fws_pkg::OP_POP, fws_pkg::OP_FRONT: begin
              if (occ_r == '0) begin
                fin      = 1'b1;
                f_status = fws_pkg::ST_EMPTY;
              end else begin
                pop_nxt   = (cmd.op == fws_pkg::OP_POP);
                state_nxt = S_RD;
              end
            end
            fws_pkg::OP_READ: begin
              if (posx >= occx) begin
                fin      = 1'b1;
                f_status = fws_pkg::ST_RANGE;
              end else begin
                ram_raddr = ring(head_r, posc);
                pop_nxt   = 1'b0;
                state_nxt = S_RD;
              end
            end
            fws_pkg::OP_FIND: begin
              val_nxt   = dval;
              idx_nxt   = '0;
              pend_nxt  = 1'b0;
              state_nxt = S_SCAN;
            end
            fws_pkg::OP_SWAP: begin
              if (posx + OW'(1) >= occx) begin
                fin      = 1'b1;
                f_status = fws_pkg::ST_RANGE;
              end else begin
                ram_raddr  = ring(head_r, posc);
                addr_a_nxt = ring(head_r, posc);
                addr_b_nxt = ring(head_r, posc + CW'(1));
                state_nxt  = S_SWB;
              end
            end
            fws_pkg::OP_CLEAR: begin
              fin      = 1'b1;
              head_nxt = '0;
              occ_nxt  = '0;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_RD: begin
        fin       = 1'b1;
        f_data    = 32'(ram_rdata);
        state_nxt = S_IDLE;
        if (pop_r) begin
          head_nxt = ring(head_r, CW'(1));
          occ_nxt  = occ_r - CW'(1);
        end
      end
      S_SCAN: begin
        // Issue one read per cycle; compare the word read in the cycle before
        if (hit) begin
          fin       = 1'b1;
          f_found   = 4'(cmp_idx_r);
          state_nxt = S_IDLE;
        end else if (idx_r < occ_r) begin
          ram_raddr   = ring(head_r, idx_r);
          pend_nxt    = 1'b1;
          cmp_idx_nxt = idx_r;
          idx_nxt     = idx_r + CW'(1);
        end else begin
          fin       = 1'b1;
          f_status  = fws_pkg::ST_EMPTY;
          state_nxt = S_IDLE;
        end
      end
      S_SWB: begin
        ram_raddr = addr_b_r;
        tmp_nxt   = ram_rdata;
        state_nxt = S_SWWA;
      end
      S_SWWA: begin
        ram_we    = 1'b1;
        ram_waddr = addr_a_r;
        ram_wdata = ram_rdata;
        state_nxt = S_SWWB;
      end
      S_SWWB: begin
        ram_we    = 1'b1;
        ram_waddr = addr_b_r;
        ram_wdata = tmp_r;
        fin       = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin) begin
      out_valid_nxt          = 1'b1;
      res_nxt.data_out       = f_data;
      res_nxt.found_position = f_found;
      res_nxt.status         = f_status;
      res_nxt.entry_count    = 5'(occ_nxt);
      res_nxt.is_empty       = (occ_nxt == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      occ_r       <= '0;
      pop_r       <= 1'b0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      occ_r       <= occ_nxt;
      pop_r       <= pop_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r     <= val_nxt;
    tmp_r     <= tmp_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    addr_a_r  <= addr_a_nxt;
    addr_b_r  <= addr_b_nxt;
    res_r     <= res_nxt;
  end

endmodule

// ===== src/fifo_with_search_and_swap.sv =====
// Channel  Dir  Payload                                                  Handshake
// in_ch    in   req_type[2:0] value[31:0] position[3:0]                  valid/ready
// out_ch   out  data_out[31:0] found_position[3:0] status[1:0]           valid/ready
//               entry_count[4:0] is_empty
//
// Execute unit: push, clear, no-op and requests refused on their checks finish in idle;
// pop, front and indexed read pass a read state; swap does two reads, then two writes;
// find reads one entry per cycle until a match or the last occupied entry is compared.
// A two-entry request queue takes new transactions while the execute unit is busy or
// its result register waits; the execute unit starts a request only once that
// register is empty. Synchronous reset empties the queue; entry RAM is not cleared.
module fifo_with_search_and_swap #(
  parameter int unsigned QUEUE_DEPTH = fws_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned DATA_WIDTH  = fws_pkg::DATA_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  fws_in_if.sink    in_ch,
  fws_out_if.source out_ch
);

  logic          cmd_valid;
  logic          cmd_ready;
  fws_pkg::cmd_t cmd;
  logic          res_valid;
  fws_pkg::res_t res;

  fws_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  fws_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_valid (res_valid),
    .out_ready (out_ch.ready),
    .out_res   (res)
  );

  assign out_ch.valid          = res_valid;
  assign out_ch.data_out       = res.data_out;
  assign out_ch.found_position = res.found_position;
  assign out_ch.status         = res.status;
  assign out_ch.entry_count    = res.entry_count;
  assign out_ch.is_empty       = res.is_empty;

  a_start_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_valid && cmd_ready |-> !res_valid)
    else $error("execute unit started with a result still pending");

  a_taken_then_drop: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && out_ch.ready |=> !res_valid)
    else $error("result repeated after transaction");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.is_empty |-> res.entry_count == 5'd0)
    else $error("empty flag with nonzero count");

  a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.status == fws_pkg::ST_FULL |-> !res.is_empty)
    else $error("full status on an empty queue");

endmodule
